// ----- hdl/sgps_pkg.sv -----
// shared types and constants of the stereo gain, pan and peak meter strip
`timescale 1ns / 1ps
`default_nettype none
package sgps_pkg;

  localparam int RAMP_EXTRA = 16;
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 5;
  localparam int TGAIN_BITS = 16;
  localparam int TPAN_BITS = 17;
  localparam int RAMP_BITS = 16;
  localparam int HOLDS_BITS = 20;
  localparam int COUNT_BITS = 20;
  localparam int HOLD_BITS = 21;

  localparam logic [TGAIN_BITS-1:0] TGAIN_RST = 16'd26214;
  localparam logic [RAMP_BITS-1:0] RAMP_RST = 16'd2400;
  localparam logic [HOLDS_BITS-1:0] HOLDS_RST = 20'd48000;
  localparam logic signed [17:0] DECAY_NUM = 18'sd65471;

  typedef enum logic [2:0] {
    REG_TARGET_GAIN,
    REG_TARGET_PAN,
    REG_RAMP_STEPS,
    REG_MONO_MODE,
    REG_USER_MUTE,
    REG_SOLO_MUTE,
    REG_HOLD_SAMPLES
  } reg_idx_t;

  typedef struct packed {
    logic [TGAIN_BITS-1:0]       target_gain;
    logic signed [TPAN_BITS-1:0] target_pan;
    logic [RAMP_BITS-1:0]        ramp_steps;
    logic                        mono_mode;
    logic                        user_mute;
    logic                        solo_mute;
    logic [HOLDS_BITS-1:0]       hold_samples;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_LCOEF,
    MUL_RCOEF,
    MUL_LOUT,
    MUL_ROUT,
    MUL_DECAY
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    clr_res;
    logic    ret_gain;
    logic    ret_pan;
    logic    div_start;
    logic    store_gstep;
    logic    store_pstep;
    logic    advance;
    mul_op_t mul_op;
    logic    meter;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic muted;
    logic first;
    logic gain_chg;
    logic pan_chg;
    logic ramp_zero;
    logic div_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hdl/sgps_if.sv -----
// stream interfaces for sample pairs and scaled results
`timescale 1ns / 1ps
`default_nettype none
interface sgps_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end;
  modport source (output valid, left_in, right_in, block_end, input ready);
  modport sink (input valid, left_in, right_in, block_end, output ready);
endinterface

interface sgps_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic [SAMPLE_BITS-1:0]        peak_level;
  modport source (output valid, left_out, right_out, peak_level, input ready);
  modport sink (input valid, left_out, right_out, peak_level, output ready);
endinterface
`default_nettype wire

// ----- hdl/stereo_gain_pan_strip_with_peak_meter.sv -----
// top level of the stereo gain, pan and peak meter strip
//
// channel     | direction | transaction
// sample_ch   | sink      | left_in, right_in, block_end
// result_ch   | source    | left_out, right_out, peak_level
// apb         | slave     | register writes and reads, 32-bit data
//
// a sample pair passes the check, advance, left and right coefficient, left and right output,
// decay and meter states before it loads the result register; the first pair of a block adds
// the gain and pan target checks, and each changed target with a nonzero ramp adds a divide
// (33 quotient bits); a muted pair goes from the check straight to the result register
// a new pair is taken once the previous one sits in the result register, and its own
// result waits until that one is accepted
// synchronous active-high reset loads the documented register and state values
`timescale 1ns / 1ps
`default_nettype none
module stereo_gain_pan_strip_with_peak_meter #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 15
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  sgps_in_if.sink                                  sample_ch,
  sgps_out_if.source                               result_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sgps_pkg::ADDR_BITS-1:0]      paddr,
  input  wire logic [sgps_pkg::DATA_BITS-1:0]      pwdata,
  output logic [sgps_pkg::DATA_BITS-1:0]           prdata,
  output logic                                     pready
);

  sgps_pkg::cfg_t     cfg;
  sgps_pkg::dp_cmd_t  cmd;
  sgps_pkg::dp_stat_t stat;
  sgps_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx = sgps_pkg::reg_idx_t'(paddr[4:2]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_gain <= sgps_pkg::TGAIN_RST;
      cfg.target_pan <= '0;
      cfg.ramp_steps <= sgps_pkg::RAMP_RST;
      cfg.mono_mode <= 1'b0;
      cfg.user_mute <= 1'b0;
      cfg.solo_mute <= 1'b0;
      cfg.hold_samples <= sgps_pkg::HOLDS_RST;
    end else if (wr) begin
      unique case (idx)
        sgps_pkg::REG_TARGET_GAIN:  cfg.target_gain <= pwdata[15:0];
        sgps_pkg::REG_TARGET_PAN:   cfg.target_pan <= pwdata[16:0];
        sgps_pkg::REG_RAMP_STEPS:   cfg.ramp_steps <= pwdata[15:0];
        sgps_pkg::REG_MONO_MODE:    cfg.mono_mode <= pwdata[0];
        sgps_pkg::REG_USER_MUTE:    cfg.user_mute <= pwdata[0];
        sgps_pkg::REG_SOLO_MUTE:    cfg.solo_mute <= pwdata[0];
        sgps_pkg::REG_HOLD_SAMPLES: cfg.hold_samples <= pwdata[19:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sgps_pkg::REG_TARGET_GAIN:  prdata = 32'(cfg.target_gain);
      sgps_pkg::REG_TARGET_PAN:   prdata = 32'(cfg.target_pan);
      sgps_pkg::REG_RAMP_STEPS:   prdata = 32'(cfg.ramp_steps);
      sgps_pkg::REG_MONO_MODE:    prdata = 32'(cfg.mono_mode);
      sgps_pkg::REG_USER_MUTE:    prdata = 32'(cfg.user_mute);
      sgps_pkg::REG_SOLO_MUTE:    prdata = 32'(cfg.solo_mute);
      sgps_pkg::REG_HOLD_SAMPLES: prdata = 32'(cfg.hold_samples);
      default:                    prdata = '0;
    endcase
  end

  sgps_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(sample_ch.valid),
    .in_ready(sample_ch.ready),
    .out_valid(result_ch.valid),
    .out_ready(result_ch.ready),
    .stat(stat),
    .cmd(cmd)
  );

  sgps_dp #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd(cmd),
    .stat(stat),
    .left_in(sample_ch.left_in),
    .right_in(sample_ch.right_in),
    .block_end(sample_ch.block_end),
    .left_out(result_ch.left_out),
    .right_out(result_ch.right_out),
    .peak_level(result_ch.peak_level)
  );

endmodule
`default_nettype wire

// ----- hdl/sgps_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sgps_div #(
  parameter int NW = 33,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(NW + 1);

  logic [DW-1:0]       rem;
  logic [DW-1:0]       dsr;
  logic [CNT_BITS-1:0] cnt;
  logic [DW:0]         trial;
  logic                qbit;

  assign trial = {rem, quotient[NW-1]};
  assign qbit = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(NW);
        rem <= '0;
        dsr <= divisor;
        quotient <= dividend;
      end else if (cnt != '0) begin
        rem <= qbit ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
        quotient <= {quotient[NW-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sgps_dp.sv -----
// datapath: ramps, shared multiplier, peak meter and result register
`timescale 1ns / 1ps
`default_nettype none
module sgps_dp #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sgps_pkg::cfg_t                cfg,
  input  wire sgps_pkg::dp_cmd_t             cmd,
  output sgps_pkg::dp_stat_t                 stat,
  input  wire logic signed [SAMPLE_BITS-1:0] left_in,
  input  wire logic signed [SAMPLE_BITS-1:0] right_in,
  input  wire logic                          block_end,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic [SAMPLE_BITS-1:0]             peak_level
);

  localparam int SB = SAMPLE_BITS;
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int NW = CW + sgps_pkg::RAMP_EXTRA;
  localparam int SW = NW + 1;
  localparam int TW = (CW > 18) ? CW : 18;
  localparam int MA = (SB + 1 > CW) ? SB + 1 : CW;
  localparam int MB = (CW > 18) ? CW : 18;
  localparam int PW = MA + MB;
  localparam logic signed [TW-1:0] UNITY_T = TW'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [CW-1:0] UNITY_C = CW'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [CW-1:0] GAIN_RST_C = CW'(sgps_pkg::TGAIN_RST);
  localparam int CB = sgps_pkg::COUNT_BITS;
  localparam int HB = sgps_pkg::HOLD_BITS;

  logic signed [SB-1:0] smp_l, smp_r;
  logic                 smp_last;
  logic signed [NW-1:0] gain_now, pan_now;
  logic signed [SW-1:0] gain_step, pan_step;
  logic [15:0]          gain_left, pan_left;
  logic signed [CW-1:0] gain_aim, pan_aim;
  logic [SB-1:0]        block_peak, meter_peak, decayed;
  logic [CB-1:0]        block_count;
  logic [HB-1:0]        hold_left;
  logic signed [CW-1:0] lcoef, rcoef;
  logic signed [SB-1:0] lo, ro;
  logic                 div_neg;

  logic signed [TW-1:0] tg_w, tp_w, tg_k, tp_k;
  logic signed [CW-1:0] tg_c, tp_c;
  logic signed [NW-1:0] full_g, full_p, full_ga, full_pa;
  logic signed [SW-1:0] diff, diff_abs, qs, gsum, psum;
  logic [NW-1:0]        quotient;
  logic                 div_done;
  logic signed [CW-1:0] g_c, p_c, lg, rg;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod, prod_c;
  logic [PW-1:0]        prod_d;
  logic [SB-1:0]        mlo, mro, peak;
  logic [HB-1:0]        n_cnt;

  // clamped targets
  assign tg_w = signed'({{(TW - sgps_pkg::TGAIN_BITS){1'b0}}, cfg.target_gain});
  assign tp_w = TW'(cfg.target_pan);
  assign tg_k = (tg_w > UNITY_T) ? UNITY_T : tg_w;
  assign tp_k = (tp_w > UNITY_T) ? UNITY_T : ((tp_w < -UNITY_T) ? -UNITY_T : tp_w);
  assign tg_c = tg_k[CW-1:0];
  assign tp_c = tp_k[CW-1:0];

  assign full_g = NW'(tg_c) <<< sgps_pkg::RAMP_EXTRA;
  assign full_p = NW'(tp_c) <<< sgps_pkg::RAMP_EXTRA;
  assign full_ga = NW'(gain_aim) <<< sgps_pkg::RAMP_EXTRA;
  assign full_pa = NW'(pan_aim) <<< sgps_pkg::RAMP_EXTRA;

  assign diff = cmd.ret_pan ? (SW'(full_p) - SW'(pan_now)) : (SW'(full_g) - SW'(gain_now));
  assign diff_abs = diff[SW-1] ? -diff : diff;

  sgps_div #(.NW(NW), .DW(sgps_pkg::RAMP_BITS)) u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_start),
    .dividend(diff_abs[NW-1:0]),
    .divisor(cfg.ramp_steps),
    .done(div_done),
    .quotient(quotient)
  );

  assign qs = div_neg ? -signed'({1'b0, quotient}) : signed'({1'b0, quotient});
  assign gsum = SW'(gain_now) + gain_step;
  assign psum = SW'(pan_now) + pan_step;

  // floor of the ramp values
  assign g_c = gain_now[NW-1:sgps_pkg::RAMP_EXTRA];
  assign p_c = pan_now[NW-1:sgps_pkg::RAMP_EXTRA];
  assign lg = (p_c <= 0) ? UNITY_C : UNITY_C - p_c;
  assign rg = (p_c >= 0) ? UNITY_C : UNITY_C + p_c;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      sgps_pkg::MUL_LCOEF: begin
        mul_a = MA'(g_c);
        mul_b = MB'(lg);
      end
      sgps_pkg::MUL_RCOEF: begin
        mul_a = MA'(g_c);
        mul_b = MB'(rg);
      end
      sgps_pkg::MUL_LOUT: begin
        mul_a = MA'(smp_l);
        mul_b = cfg.mono_mode ? MB'(g_c) : MB'(lcoef);
      end
      sgps_pkg::MUL_ROUT: begin
        mul_a = MA'(smp_r);
        mul_b = MB'(rcoef);
      end
      sgps_pkg::MUL_DECAY: begin
        mul_a = MA'(signed'({1'b0, meter_peak}));
        mul_b = MB'(sgps_pkg::DECAY_NUM);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign prod_c = prod >>> COEF_FRAC_BITS;
  assign prod_d = prod >> 16;

  // block peak including this sample
  assign mlo = lo[SB-1] ? SB'(-lo) : lo;
  assign mro = ro[SB-1] ? SB'(-ro) : ro;
  always_comb begin
    peak = block_peak;
    if (mlo > peak) begin
      peak = mlo;
    end
    if (mro > peak) begin
      peak = mro;
    end
  end
  assign n_cnt = HB'(block_count) + HB'(1);

  assign stat.muted = cfg.user_mute | cfg.solo_mute;
  assign stat.first = (block_count == '0);
  assign stat.gain_chg = (tg_c != gain_aim);
  assign stat.pan_chg = (tp_c != pan_aim);
  assign stat.ramp_zero = (cfg.ramp_steps == '0);
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_now <= NW'(GAIN_RST_C) <<< sgps_pkg::RAMP_EXTRA;
      gain_step <= '0;
      gain_left <= '0;
      gain_aim <= GAIN_RST_C;
      pan_now <= '0;
      pan_step <= '0;
      pan_left <= '0;
      pan_aim <= '0;
      block_peak <= '0;
      block_count <= '0;
      meter_peak <= '0;
      hold_left <= '0;
    end else begin
      if (cmd.ret_gain) begin
        gain_aim <= tg_c;
        if (cfg.ramp_steps == '0) begin
          gain_now <= full_g;
          gain_step <= '0;
          gain_left <= '0;
        end else begin
          gain_left <= cfg.ramp_steps;
        end
      end
      if (cmd.ret_pan) begin
        pan_aim <= tp_c;
        if (cfg.ramp_steps == '0) begin
          pan_now <= full_p;
          pan_step <= '0;
          pan_left <= '0;
        end else begin
          pan_left <= cfg.ramp_steps;
        end
      end
      if (cmd.store_gstep) begin
        gain_step <= qs;
      end
      if (cmd.store_pstep) begin
        pan_step <= qs;
      end
      if (cmd.advance) begin
        if (gain_left == '0) begin
          gain_now <= full_ga;
        end else begin
          gain_left <= gain_left - 1'b1;
          gain_now <= (gain_left != 16'd1) ? gsum[NW-1:0] : full_ga;
        end
        if (pan_left == '0) begin
          pan_now <= full_pa;
        end else begin
          pan_left <= pan_left - 1'b1;
          pan_now <= (pan_left != 16'd1) ? psum[NW-1:0] : full_pa;
        end
      end
      if (cmd.meter) begin
        if (smp_last) begin
          if (peak > meter_peak || hold_left == '0) begin
            meter_peak <= peak;
            hold_left <= HB'(cfg.hold_samples);
          end else begin
            hold_left <= (hold_left > n_cnt) ? hold_left - n_cnt : '0;
            meter_peak <= (peak > decayed) ? peak : decayed;
          end
          block_peak <= '0;
          block_count <= '0;
        end else begin
          block_peak <= peak;
          if (block_count != '1) begin
            block_count <= block_count + 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      smp_l <= left_in;
      smp_r <= right_in;
      smp_last <= block_end;
    end
    if (cmd.div_start) begin
      div_neg <= diff[SW-1];
    end
    if (cmd.clr_res) begin
      lo <= '0;
      ro <= '0;
    end
    unique case (cmd.mul_op)
      sgps_pkg::MUL_LCOEF: lcoef <= prod_c[CW-1:0];
      sgps_pkg::MUL_RCOEF: rcoef <= prod_c[CW-1:0];
      sgps_pkg::MUL_LOUT:  lo <= prod_c[SB-1:0];
      sgps_pkg::MUL_ROUT:  ro <= cfg.mono_mode ? '0 : prod_c[SB-1:0];
      sgps_pkg::MUL_DECAY: decayed <= prod_d[SB-1:0];
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      left_out <= lo;
      right_out <= ro;
      peak_level <= meter_peak;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sgps_ctrl.sv -----
// controller: sequences one sample pair through the datapath
`timescale 1ns / 1ps
`default_nettype none
module sgps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire sgps_pkg::dp_stat_t stat,
  output sgps_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_RG, S_WG, S_RP, S_WP, S_ADV,
    S_LC, S_RC, S_LO, S_RO, S_DC, S_MT, S_OUT
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.muted) begin
          cmd.clr_res = 1'b1;
          state_next = S_OUT;
        end else if (stat.first) begin
          state_next = S_RG;
        end else begin
          state_next = S_ADV;
        end
      end
      S_RG: begin
        state_next = S_RP;
        if (stat.gain_chg) begin
          cmd.ret_gain = 1'b1;
          if (!stat.ramp_zero) begin
            cmd.div_start = 1'b1;
            state_next = S_WG;
          end
        end
      end
      S_WG: begin
        if (stat.div_done) begin
          cmd.store_gstep = 1'b1;
          state_next = S_RP;
        end
      end
      S_RP: begin
        state_next = S_ADV;
        if (stat.pan_chg) begin
          cmd.ret_pan = 1'b1;
          if (!stat.ramp_zero) begin
            cmd.div_start = 1'b1;
            state_next = S_WP;
          end
        end
      end
      S_WP: begin
        if (stat.div_done) begin
          cmd.store_pstep = 1'b1;
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next = S_LC;
      end
      S_LC: begin
        cmd.mul_op = sgps_pkg::MUL_LCOEF;
        state_next = S_RC;
      end
      S_RC: begin
        cmd.mul_op = sgps_pkg::MUL_RCOEF;
        state_next = S_LO;
      end
      S_LO: begin
        cmd.mul_op = sgps_pkg::MUL_LOUT;
        state_next = S_RO;
      end
      S_RO: begin
        cmd.mul_op = sgps_pkg::MUL_ROUT;
        state_next = S_DC;
      end
      S_DC: begin
        cmd.mul_op = sgps_pkg::MUL_DECAY;
        state_next = S_MT;
      end
      S_MT: begin
        cmd.meter = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sgps_chk.sv -----
// port-level checker for the strip and its bind
`timescale 1ns / 1ps
`default_nettype none
module sgps_chk #(
  parameter int SAMPLE_BITS = 24
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] left_out,
  input wire logic [SAMPLE_BITS-1:0] right_out,
  input wire logic [SAMPLE_BITS-1:0] peak_level
);

  logic       in_acc, out_acc;
  logic [1:0] pending;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(left_out) && $stable(right_out) && $stable(peak_level))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0) else $error("result without a sample pair");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready) else $error("second pair taken while busy");

endmodule

bind stereo_gain_pan_strip_with_peak_meter sgps_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(sample_ch.valid),
  .in_ready(sample_ch.ready),
  .out_valid(result_ch.valid),
  .out_ready(result_ch.ready),
  .left_out(result_ch.left_out),
  .right_out(result_ch.right_out),
  .peak_level(result_ch.peak_level)
);
`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench for the stereo gain, pan and peak meter strip
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int SB = 24;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 last;
  } pair_t;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic [SB-1:0]        peak;
  } scaled_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [sgps_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [sgps_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [sgps_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  sgps_in_if #(SB) sample_ch ();
  sgps_out_if #(SB) result_ch ();

  stereo_gain_pan_strip_with_peak_meter uut (
    .clk(clk), .rst(rst), .sample_ch(sample_ch), .result_ch(result_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [15:0] c_gain = sgps_pkg::TGAIN_RST;
  logic signed [16:0] c_pan = '0;
  logic [15:0] c_ramp = sgps_pkg::RAMP_RST;
  logic c_mono = 0, c_umute = 0, c_smute = 0;
  logic [19:0] c_hold = sgps_pkg::HOLDS_RST;

  longint g_now, g_step, p_now, p_step;
  int unsigned g_left, p_left;
  int g_aim, p_aim;
  int unsigned blk_peak, blk_cnt, mtr_peak, hold_cnt;

  pair_t pending_pairs[$];
  scaled_t expected_scaled[$];

  int errors = 0;
  int n_scaled = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  int watch = 0;

  function automatic longint floor_sh(longint x, int k);
    return x >>> k;
  endfunction

  task automatic retarget(inout longint now, inout longint step, inout int unsigned left,
                          inout int aim, input int t);
    longint full;
    full = longint'(t) * 65536;
    if (t != aim) begin
      aim = t;
      if (c_ramp == 0) begin
        now = full;
        step = 0;
        left = 0;
      end else begin
        left = c_ramp;
        step = (full - now) / longint'(c_ramp);
      end
    end
  endtask

  task automatic advance(inout longint now, input longint step, inout int unsigned left,
                         input int aim);
    longint full;
    full = longint'(aim) * 65536;
    if (left == 0) now = full;
    else begin
      left--;
      if (left > 0) now += step;
      else now = full;
    end
  endtask

  function automatic int unsigned mag(longint v);
    return int'(v < 0 ? -v : v);
  endfunction

  task automatic scale_pair(input pair_t s);
    scaled_t r;
    longint g, p, lg, rg, lo, ro;
    int tg, tp;
    int unsigned pk, n, dec;
    if (c_umute || c_smute) begin
      r = '{0, 0, mtr_peak[SB-1:0]};
      expected_scaled.push_back(r);
      return;
    end
    if (blk_cnt == 0) begin
      tg = c_gain > 32768 ? 32768 : int'(c_gain);
      tp = int'(c_pan);
      if (tp > 32768) tp = 32768;
      if (tp < -32768) tp = -32768;
      retarget(g_now, g_step, g_left, g_aim, tg);
      retarget(p_now, p_step, p_left, p_aim, tp);
    end
    advance(g_now, g_step, g_left, g_aim);
    advance(p_now, p_step, p_left, p_aim);
    g = floor_sh(g_now, 16);
    p = floor_sh(p_now, 16);
    if (c_mono) begin
      lo = floor_sh(longint'(s.left) * g, 15);
      ro = 0;
    end else begin
      lg = (p <= 0) ? 32768 : 32768 - p;
      rg = (p >= 0) ? 32768 : 32768 + p;
      lg = (g * lg) >>> 15;
      rg = (g * rg) >>> 15;
      lo = floor_sh(longint'(s.left) * lg, 15);
      ro = floor_sh(longint'(s.right) * rg, 15);
    end
    pk = blk_peak;
    if (mag(lo) > pk) pk = mag(lo);
    if (mag(ro) > pk) pk = mag(ro);
    if (s.last) begin
      n = blk_cnt + 1;
      if (pk > mtr_peak || hold_cnt == 0) begin
        mtr_peak = pk;
        hold_cnt = c_hold;
      end else begin
        hold_cnt = hold_cnt > n ? hold_cnt - n : 0;
        dec = int'((longint'(mtr_peak) * 65471) >> 16);
        mtr_peak = pk > dec ? pk : dec;
      end
      blk_peak = 0;
      blk_cnt = 0;
    end else begin
      blk_peak = pk;
      if (blk_cnt < 1048575) blk_cnt++;
    end
    r.left = lo[SB-1:0];
    r.right = ro[SB-1:0];
    r.peak = mtr_peak[SB-1:0];
    expected_scaled.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
        pair_t s;
        s = pending_pairs.pop_front();
        scale_pair(s);
        sample_ch.valid <= 1;
        sample_ch.left_in <= s.left;
        sample_ch.right_in <= s.right;
        sample_ch.block_end <= s.last;
      end else begin
        sample_ch.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_scaled.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          scaled_t e;
          e = expected_scaled.pop_front();
          n_scaled++;
          if (result_ch.left_out !== e.left) report("left_out", result_ch.left_out, e.left);
          if (result_ch.right_out !== e.right)
            report("right_out", result_ch.right_out, e.right);
          if (result_ch.peak_level !== e.peak)
            report("peak_level", result_ch.peak_level, e.peak);
        end
      end
      result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (pending_pairs.size() == 0 && expected_scaled.size() == 0))
        watch <= 0;
      else
        watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCH_LIMIT);
        $display("stereo_gain_pan_strip_with_peak_meter test failed");
        $finish;
      end
    end
  end

  task automatic reg_write(input sgps_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= sgps_pkg::ADDR_BITS'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      sgps_pkg::REG_TARGET_GAIN: c_gain = val[15:0];
      sgps_pkg::REG_TARGET_PAN: c_pan = val[16:0];
      sgps_pkg::REG_RAMP_STEPS: c_ramp = val[15:0];
      sgps_pkg::REG_MONO_MODE: c_mono = val[0];
      sgps_pkg::REG_USER_MUTE: c_umute = val[0];
      sgps_pkg::REG_SOLO_MUTE: c_smute = val[0];
      sgps_pkg::REG_HOLD_SAMPLES: c_hold = val[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_pairs.size() > 0 || expected_scaled.size() > 0 || sample_ch.valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return SB'(int'($urandom_range(255)) - 128);
      default: return SB'($urandom);
    endcase
  endfunction

  // blocks of random length, with occasional long ones and early ends; the last may lack an end
  task automatic queue_blocks(input int pairs);
    pair_t s;
    int len, k;
    k = 0;
    while (k < pairs) begin
      len = ($urandom_range(19) == 0) ? int'($urandom_range(40, 80)) :
            int'($urandom_range(1, 12));
      for (int j = 0; j < len && k < pairs; j++, k++) begin
        s.left = rand_sample();
        s.right = rand_sample();
        s.last = (j == len - 1) || ($urandom_range(49) == 0);
        pending_pairs.push_back(s);
      end
    end
  endtask

  task automatic random_cfg();
    int sel;
    sel = $urandom_range(4);
    reg_write(sgps_pkg::REG_TARGET_GAIN,
              sel == 0 ? 32'(16'hffff) : sel == 1 ? 32'd0 : 32'($urandom_range(40000)));
    sel = $urandom_range(4);
    reg_write(sgps_pkg::REG_TARGET_PAN, sel == 0 ? 32'h10000 : sel == 1 ? 32'h0ffff :
              sel == 2 ? 32'(17'h08000) : 32'($urandom));
    sel = $urandom_range(5);
    reg_write(sgps_pkg::REG_RAMP_STEPS,
              sel == 0 ? 32'd0 : sel == 1 ? 32'hffff : 32'($urandom_range(1, 20)));
    reg_write(sgps_pkg::REG_MONO_MODE, 32'($urandom_range(3) == 0));
    reg_write(sgps_pkg::REG_HOLD_SAMPLES,
              $urandom_range(3) == 0 ? 32'hfffff : 32'($urandom_range(0, 60)));
  endtask

  initial begin
    pair_t s;
    g_now = longint'(sgps_pkg::TGAIN_RST) * 65536;
    g_step = 0; g_left = 0; g_aim = int'(sgps_pkg::TGAIN_RST);
    p_now = 0; p_step = 0; p_left = 0; p_aim = 0;
    blk_peak = 0; blk_cnt = 0; mtr_peak = 0; hold_cnt = 0;
    sample_ch.valid = 0;
    sample_ch.left_in = 0;
    sample_ch.right_in = 0;
    sample_ch.block_end = 0;
    result_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, ramps, mono, user and solo mutes
    reg_write(sgps_pkg::REG_RAMP_STEPS, 3);
    reg_write(sgps_pkg::REG_TARGET_GAIN, 32768);
    reg_write(sgps_pkg::REG_TARGET_PAN, 32'h1ffff);
    reg_write(sgps_pkg::REG_HOLD_SAMPLES, 4);
    for (int i = 0; i < 8; i++) begin
      s.left = i[0] ? 24'sh800000 : 24'sh7fffff;
      s.right = i[1] ? 24'sh7fffff : 24'sh800000;
      s.last = i[0];
      pending_pairs.push_back(s);
    end
    drain();
    reg_write(sgps_pkg::REG_USER_MUTE, 1);
    s = '{24'sh123456, -24'sh1, 1'b1};
    pending_pairs.push_back(s);
    drain();
    reg_write(sgps_pkg::REG_USER_MUTE, 0);
    reg_write(sgps_pkg::REG_SOLO_MUTE, 1);
    pending_pairs.push_back(s);
    drain();
    reg_write(sgps_pkg::REG_SOLO_MUTE, 0);
    reg_write(sgps_pkg::REG_MONO_MODE, 1);
    reg_write(sgps_pkg::REG_RAMP_STEPS, 0);
    reg_write(sgps_pkg::REG_TARGET_GAIN, 32'hffff);
    for (int i = 0; i < 4; i++) begin
      s = '{rand_sample(), rand_sample(), i == 3};
      pending_pairs.push_back(s);
    end
    drain();
    reg_write(sgps_pkg::REG_MONO_MODE, 0);
    reg_write(sgps_pkg::REG_TARGET_PAN, 32'h10000);
    reg_write(sgps_pkg::REG_TARGET_GAIN, 0);
    queue_blocks(6);
    drain();

    // random phases with different idle mixes
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 57; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 57; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      random_cfg();
      if (ph % 5 == 4) begin
        reg_write($urandom_range(1) ? sgps_pkg::REG_USER_MUTE : sgps_pkg::REG_SOLO_MUTE, 1);
        queue_blocks(10);
        drain();
        reg_write(sgps_pkg::REG_USER_MUTE, 0);
        reg_write(sgps_pkg::REG_SOLO_MUTE, 0);
      end
      queue_blocks(78);
      if (ph == 6) begin
        hold_off = 1;
        repeat (2000) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end

    $display("covered %0d scaled pairs across ramp, pan, mono, mute and meter hold settings",
             n_scaled);
    $display("idle mixes: none, sender, receiver and both; one long receiver hold-off");
    if (errors == 0) begin
      $display("stereo_gain_pan_strip_with_peak_meter test passed");
    end else begin
      $display("stereo_gain_pan_strip_with_peak_meter test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
